### rtl/rcpc_pkg.sv
// Package with shared types, constants and helper functions of the ray polygon clipper.
package rcpc_pkg;

   localparam int MAX_VERTICES_DEF = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 38;
   localparam int ACC_W = 55;
   localparam int MAG_W = 54;
   localparam int FRAC_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_COS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SIN = 3'd4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [FRAC_W-1:0] FRAC_SAT = 18'h20000;
   localparam logic signed [18:0] FRAC_ONE = 19'sd65536;

   typedef enum logic [1:0] {
      MAC_NOP,
      MAC_LOAD,
      MAC_ADD,
      MAC_SUB
   } mac_op_type;

   typedef struct packed {
      mac_op_type op;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mac_req_type;

   typedef struct packed {
      logic start;
      logic [MAG_W-1:0] num;
      logic [MAG_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [FRAC_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [15:0] clamp_unit(input logic signed [ACC_W-1:0] v);
      logic signed [15:0] r;
      if (v > 55'sd16384) begin
         r = 16'sd16384;
      end else if (v < -55'sd16384) begin
         r = -16'sd16384;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### rtl/rcpc_req_if.sv
// Request channel interface carrying vertex loads and ray queries.
interface rcpc_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [2:0] vertex_index;
   logic signed [31:0] vert_x;
   logic signed [31:0] vert_y;
   logic signed [15:0] edge_nx;
   logic signed [15:0] edge_ny;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic [30:0] ray_length;

   modport source (output valid, operation, vertex_index, vert_x, vert_y, edge_nx, edge_ny,
                   origin_x, origin_y, dir_x, dir_y, ray_length, input ready);
   modport sink (input valid, operation, vertex_index, vert_x, vert_y, edge_nx, edge_ny,
                 origin_x, origin_y, dir_x, dir_y, ray_length, output ready);
endinterface

### rtl/rcpc_rsp_if.sv
// Response channel interface carrying the query results.
interface rcpc_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [16:0] hit_fraction;
   logic signed [15:0] hit_normal_x;
   logic signed [15:0] hit_normal_y;

   modport source (output valid, hit, hit_fraction, hit_normal_x, hit_normal_y, input ready);
   modport sink (input valid, hit, hit_fraction, hit_normal_x, hit_normal_y, output ready);
endinterface

### rtl/rcpc_mac.sv
// Shared multiply-accumulate unit used by the sequencer for every product.
module rcpc_mac
   import rcpc_pkg::*;
(
   input  logic clock,
   input  mac_req_type mac_req,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [MUL_A_W+MUL_B_W-1:0] prod;

   assign prod = mac_req.a * mac_req.b;

   always_comb begin
      unique case (mac_req.op)
         MAC_NOP:  acc_in = acc_ff;
         MAC_LOAD: acc_in = ACC_W'(prod);
         MAC_ADD:  acc_in = acc_ff + ACC_W'(prod);
         MAC_SUB:  acc_in = acc_ff - ACC_W'(prod);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/rcpc_div.sv
// Restoring serial divider that forms the saturated edge fraction one bit a cycle.
module rcpc_div
   import rcpc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic busy_ff;
   logic done_ff;
   logic [4:0] cnt_ff;
   logic [MAG_W-1:0] rem_ff;
   logic [MAG_W-1:0] den_ff;
   logic [FRAC_W-1:0] quot_ff;
   logic [MAG_W:0] rem2;
   logic ge;

   assign rem2 = {rem_ff, 1'b0};
   assign ge = rem2 >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            den_ff <= div_req.den;
            if ({1'b0, div_req.num} >= {div_req.den, 1'b0}) begin
               quot_ff <= FRAC_SAT;
               done_ff <= 1'b1;
            end else if (div_req.num >= div_req.den) begin
               quot_ff <= FRAC_W'(1);
               rem_ff <= div_req.num - div_req.den;
               cnt_ff <= 5'd16;
               busy_ff <= 1'b1;
            end else begin
               quot_ff <= '0;
               rem_ff <= div_req.num;
               cnt_ff <= 5'd16;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= ge ? MAG_W'(rem2 - {1'b0, den_ff}) : MAG_W'(rem2);
            quot_ff <= {quot_ff[FRAC_W-2:0], ge};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### rtl/ray_convex_polygon_clip.sv
// Top level: polygon store, pose registers and the clipping sequencer.
// A load beat gives no response. A query runs the setup products, then per edge a store read,
// the edge products, a decision and, where the signs call for one, a serial divide; then the
// world normal of a hit and the response beat. The shared multiply-accumulate unit and the
// serial divider form the products and quotients; a held response stalls the output step.
// Reset is synchronous and active high; the vertex store stays undefined until loaded.
module ray_convex_polygon_clip
   import rcpc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
)(
   input  logic clock,
   input  logic reset,
   rcpc_req_if.sink req_bus,
   rcpc_rsp_if.source rsp_bus,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SETUP, S_EREAD, S_EMUL, S_EDEC, S_EDIV, S_NORM, S_OUT
   } state_type;

   state_type state_ff;
   logic [3:0] step_ff;
   logic [CW-1:0] idx_ff, edges_ff, edges_in, next_idx;

   logic [3:0] vc_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic signed [15:0] cos_ff, sin_ff;

   logic signed [32:0] sx_ff, sy_ff;
   logic signed [15:0] dirx_ff, diry_ff;
   logic [30:0] len_ff;
   logic signed [33:0] rx_ff, ry_ff;
   logic signed [35:0] p1x_ff, p1y_ff, dx_ff, dy_ff;
   logic signed [ACC_W-1:0] num_ff, den_ff;
   logic signed [18:0] low_ff, high_ff;
   logic found_ff, hit_ff;
   logic signed [15:0] enx_ff, eny_ff, wx_ff, wy_ff;

   logic [63:0] vmem [MAX_VERTICES];
   logic [31:0] nmem [MAX_VERTICES];
   logic [63:0] vrd_ff;
   logic [31:0] nrd_ff;

   logic rsp_valid_ff, rsp_hit_ff;
   logic [16:0] rsp_frac_ff;
   logic signed [15:0] rsp_nx_ff, rsp_ny_ff;

   mac_req_type mac_req;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic signed [ACC_W-1:0] acc, sh;

   logic req_acc, load_we;
   logic signed [31:0] vx, vy;
   logic signed [15:0] nx, ny;
   logic num_neg, den_neg, den_zero, last_edge, hit_ok;
   logic signed [18:0] q_s;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_acc = req_bus.valid && req_bus.ready;
   assign load_we = req_acc && (req_bus.operation == OP_LOAD) &&
                    (7'(req_bus.vertex_index) < 7'(MAX_VERTICES));

   assign vx = $signed(vrd_ff[31:0]);
   assign vy = $signed(vrd_ff[63:32]);
   assign nx = $signed(nrd_ff[15:0]);
   assign ny = $signed(nrd_ff[31:16]);
   assign sh = acc >>> 14;

   assign num_neg = num_ff[ACC_W-1];
   assign den_neg = den_ff[ACC_W-1];
   assign den_zero = (den_ff == '0);
   assign next_idx = idx_ff + CW'(1);
   assign last_edge = (next_idx == edges_ff);
   assign q_s = $signed({1'b0, div_rsp.quot});

   always_comb begin
      if ({3'b000, req_bus.operation == OP_QUERY ? vc_ff : 4'd0} >= 7'(MAX_VERTICES)) begin
         edges_in = CW'(MAX_VERTICES);
      end else begin
         edges_in = CW'(vc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 4'd4;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         cos_ff <= 16'sd16384;
         sin_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vc_ff <= csr_wdata[3:0];
            CSR_POS_X:        pos_x_ff <= $signed(csr_wdata);
            CSR_POS_Y:        pos_y_ff <= $signed(csr_wdata);
            CSR_ROT_COS:      cos_ff <= $signed(csr_wdata[15:0]);
            CSR_ROT_SIN:      sin_ff <= $signed(csr_wdata[15:0]);
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         vmem[AW'(req_bus.vertex_index)] <= {req_bus.vert_y, req_bus.vert_x};
         nmem[AW'(req_bus.vertex_index)] <= {req_bus.edge_ny, req_bus.edge_nx};
      end
      if (state_ff == S_EREAD) begin
         vrd_ff <= vmem[idx_ff[AW-1:0]];
         nrd_ff <= nmem[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      mac_req.op = MAC_NOP;
      mac_req.a = cos_ff;
      mac_req.b = '0;
      if (state_ff == S_SETUP) begin
         unique case (step_ff)
            4'd0: begin mac_req.op = MAC_LOAD; mac_req.a = dirx_ff; mac_req.b = {7'b0, len_ff}; end
            4'd1: begin mac_req.op = MAC_LOAD; mac_req.a = diry_ff; mac_req.b = {7'b0, len_ff}; end
            4'd2: begin mac_req.op = MAC_LOAD; mac_req.a = cos_ff; mac_req.b = MUL_B_W'(sx_ff); end
            4'd3: begin mac_req.op = MAC_ADD; mac_req.a = sin_ff; mac_req.b = MUL_B_W'(sy_ff); end
            4'd4: begin mac_req.op = MAC_LOAD; mac_req.a = cos_ff; mac_req.b = MUL_B_W'(sy_ff); end
            4'd5: begin mac_req.op = MAC_SUB; mac_req.a = sin_ff; mac_req.b = MUL_B_W'(sx_ff); end
            4'd6: begin mac_req.op = MAC_LOAD; mac_req.a = cos_ff; mac_req.b = MUL_B_W'(rx_ff); end
            4'd7: begin mac_req.op = MAC_ADD; mac_req.a = sin_ff; mac_req.b = MUL_B_W'(ry_ff); end
            4'd8: begin mac_req.op = MAC_LOAD; mac_req.a = cos_ff; mac_req.b = MUL_B_W'(ry_ff); end
            4'd9: begin mac_req.op = MAC_SUB; mac_req.a = sin_ff; mac_req.b = MUL_B_W'(rx_ff); end
            default: ;
         endcase
      end else if (state_ff == S_EMUL) begin
         unique case (step_ff)
            4'd0: begin
               mac_req.op = MAC_LOAD; mac_req.a = nx;
               mac_req.b = MUL_B_W'(vx) - MUL_B_W'(p1x_ff);
            end
            4'd1: begin
               mac_req.op = MAC_ADD; mac_req.a = ny;
               mac_req.b = MUL_B_W'(vy) - MUL_B_W'(p1y_ff);
            end
            4'd2: begin mac_req.op = MAC_LOAD; mac_req.a = nx; mac_req.b = MUL_B_W'(dx_ff); end
            4'd3: begin mac_req.op = MAC_ADD; mac_req.a = ny; mac_req.b = MUL_B_W'(dy_ff); end
            default: ;
         endcase
      end else if (state_ff == S_NORM) begin
         unique case (step_ff)
            4'd0: begin mac_req.op = MAC_LOAD; mac_req.a = cos_ff; mac_req.b = MUL_B_W'(enx_ff); end
            4'd1: begin mac_req.op = MAC_SUB; mac_req.a = sin_ff; mac_req.b = MUL_B_W'(eny_ff); end
            4'd2: begin mac_req.op = MAC_LOAD; mac_req.a = sin_ff; mac_req.b = MUL_B_W'(enx_ff); end
            4'd3: begin mac_req.op = MAC_ADD; mac_req.a = cos_ff; mac_req.b = MUL_B_W'(eny_ff); end
            default: ;
         endcase
      end
   end

   always_comb begin
      div_req.start = (state_ff == S_EDEC) && !den_zero && !num_neg && !den_neg;
      div_req.num = MAG_W'(num_ff);
      div_req.den = MAG_W'(den_ff);
      if (state_ff == S_EDEC && den_neg) begin
         div_req.start = num_neg;
         div_req.num = MAG_W'(-num_ff);
         div_req.den = MAG_W'(-den_ff);
      end
   end

   assign hit_ok = found_ff && !(high_ff < low_ff);

   rcpc_mac u_mac (
      .clock   (clock),
      .mac_req (mac_req),
      .acc     (acc)
   );

   rcpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         idx_ff <= '0;
         edges_ff <= '0;
         found_ff <= 1'b0;
         hit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc && req_bus.operation == OP_QUERY) begin
                  sx_ff <= 33'(req_bus.origin_x) - 33'(pos_x_ff);
                  sy_ff <= 33'(req_bus.origin_y) - 33'(pos_y_ff);
                  dirx_ff <= req_bus.dir_x;
                  diry_ff <= req_bus.dir_y;
                  len_ff <= req_bus.ray_length;
                  edges_ff <= edges_in;
                  idx_ff <= '0;
                  low_ff <= '0;
                  high_ff <= FRAC_ONE;
                  found_ff <= 1'b0;
                  hit_ff <= 1'b0;
                  step_ff <= '0;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               step_ff <= step_ff + 4'd1;
               unique case (step_ff)
                  4'd1:  rx_ff <= sh[33:0];
                  4'd2:  ry_ff <= sh[33:0];
                  4'd4:  p1x_ff <= sh[35:0];
                  4'd6:  p1y_ff <= sh[35:0];
                  4'd8:  dx_ff <= sh[35:0];
                  4'd10: dy_ff <= sh[35:0];
                  default: ;
               endcase
               if (step_ff == 4'd10) begin
                  state_ff <= (edges_ff == '0) ? S_OUT : S_EREAD;
               end
            end
            S_EREAD: begin
               step_ff <= '0;
               state_ff <= S_EMUL;
            end
            S_EMUL: begin
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd2) begin
                  num_ff <= acc;
               end
               if (step_ff == 4'd4) begin
                  den_ff <= acc;
                  state_ff <= S_EDEC;
               end
            end
            S_EDEC: begin
               if (div_req.start) begin
                  state_ff <= S_EDIV;
               end else if (den_zero && num_neg) begin
                  found_ff <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  if (!den_zero && !den_neg) begin
                     high_ff <= -19'sd1;
                  end
                  idx_ff <= next_idx;
                  step_ff <= '0;
                  state_ff <= last_edge ? S_NORM : S_EREAD;
               end
            end
            S_EDIV: begin
               if (div_rsp.done) begin
                  if (den_neg) begin
                     if (q_s > low_ff) begin
                        low_ff <= q_s;
                        found_ff <= 1'b1;
                        enx_ff <= nx;
                        eny_ff <= ny;
                     end
                  end else if (q_s < high_ff) begin
                     high_ff <= q_s;
                  end
                  idx_ff <= next_idx;
                  step_ff <= '0;
                  state_ff <= last_edge ? S_NORM : S_EREAD;
               end
            end
            S_NORM: begin
               step_ff <= step_ff + 4'd1;
               hit_ff <= hit_ok;
               if (!hit_ok) begin
                  state_ff <= S_OUT;
               end
               if (step_ff == 4'd2) begin
                  wx_ff <= clamp_unit(sh);
               end
               if (step_ff == 4'd4) begin
                  wy_ff <= clamp_unit(sh);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff <= hit_ff;
                  rsp_frac_ff <= hit_ff ? low_ff[16:0] : '0;
                  rsp_nx_ff <= hit_ff ? wx_ff : '0;
                  rsp_ny_ff <= hit_ff ? wy_ff : '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.hit = rsp_hit_ff;
   assign rsp_bus.hit_fraction = rsp_frac_ff;
   assign rsp_bus.hit_normal_x = rsp_nx_ff;
   assign rsp_bus.hit_normal_y = rsp_ny_ff;

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_EDIV)
      else $error("Divider finished outside the divide state.");

   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EREAD |-> idx_ff < edges_ff)
      else $error("Edge index beyond the edge count.");

   a_hit_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_frac_ff <= 17'd65536)
      else $error("Hit fraction above one.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_frac_ff == '0 && rsp_nx_ff == '0)
      else $error("Miss response carries data.");

endmodule

### bench/rcpc_clip_checker.sv
// Checker that predicts ray clip results from the observed beats and compares responses.
module rcpc_clip_checker
   import rcpc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rcpc_req_if req_mon,
   rcpc_rsp_if rsp_mon,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int fail_count,
   output int pending_count
);

   typedef struct {
      logic hit;
      logic [16:0] fraction;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
   } clip_result_t;

   clip_result_t clip_q[$];
   longint poly_vx[8], poly_vy[8], poly_nx[8], poly_ny[8];
   longint edge_limit, body_x, body_y, body_cos, body_sin;

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   function automatic longint edge_fraction(input longint a, input longint b);
      longint q, rem;
      if (a >= 2 * b) return 131072;
      q = (a >= b) ? 1 : 0;
      rem = (q != 0) ? a - b : a;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= b) begin
            rem = rem - b;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic longint clamp_q14(input longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic clip_result_t clip_ray(input longint ox, input longint oy,
                                             input longint dirx, input longint diry,
                                             input longint len);
      clip_result_t res;
      longint sx, sy, rx, ry, p1x, p1y, dx, dy, num, den, q, lo, hi, wx, wy, edges;
      int entering;
      res = '{1'b0, 17'd0, 16'sd0, 16'sd0};
      lo = 0;
      hi = 65536;
      entering = -1;
      sx = ox - body_x;
      sy = oy - body_y;
      rx = (dirx * len) >>> 14;
      ry = (diry * len) >>> 14;
      p1x = (body_cos * sx + body_sin * sy) >>> 14;
      p1y = (body_cos * sy - body_sin * sx) >>> 14;
      dx = (body_cos * rx + body_sin * ry) >>> 14;
      dy = (body_cos * ry - body_sin * rx) >>> 14;
      edges = (edge_limit < 8) ? edge_limit : 8;
      for (int i = 0; i < edges; i++) begin
         num = poly_nx[i] * (poly_vx[i] - p1x) + poly_ny[i] * (poly_vy[i] - p1y);
         den = poly_nx[i] * dx + poly_ny[i] * dy;
         if (den == 0) begin
            if (num < 0) return res;
         end else if (den < 0) begin
            if (num < 0) begin
               q = edge_fraction(-num, -den);
               if (q > lo) begin
                  lo = q;
                  entering = i;
               end
            end
         end else if (num < 0) begin
            hi = -1;
         end else begin
            q = edge_fraction(num, den);
            if (q < hi) hi = q;
         end
      end
      if (hi < lo || entering < 0) return res;
      wx = clamp_q14((body_cos * poly_nx[entering] - body_sin * poly_ny[entering]) >>> 14);
      wy = clamp_q14((body_sin * poly_nx[entering] + body_cos * poly_ny[entering]) >>> 14);
      res.hit = 1'b1;
      res.fraction = lo[16:0];
      res.normal_x = wx[15:0];
      res.normal_y = wy[15:0];
      return res;
   endfunction

   always @(posedge clock) begin
      clip_result_t got, want;
      if (reset) begin
         edge_limit = 4;
         body_x = 0;
         body_y = 0;
         body_cos = 16384;
         body_sin = 0;
         clip_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VERTEX_COUNT: edge_limit = longint'(csr_wdata[3:0]);
               CSR_POS_X: body_x = longint'(signed'(csr_wdata));
               CSR_POS_Y: body_y = longint'(signed'(csr_wdata));
               CSR_ROT_COS: body_cos = longint'(signed'(csr_wdata[15:0]));
               CSR_ROT_SIN: body_sin = longint'(signed'(csr_wdata[15:0]));
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.operation == OP_QUERY) begin
               clip_q.push_back(clip_ray(longint'(req_mon.origin_x),
                                         longint'(req_mon.origin_y),
                                         longint'(req_mon.dir_x), longint'(req_mon.dir_y),
                                         longint'(req_mon.ray_length)));
            end else begin
               poly_vx[req_mon.vertex_index] = longint'(req_mon.vert_x);
               poly_vy[req_mon.vertex_index] = longint'(req_mon.vert_y);
               poly_nx[req_mon.vertex_index] = longint'(req_mon.edge_nx);
               poly_ny[req_mon.vertex_index] = longint'(req_mon.edge_ny);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.hit, rsp_mon.hit_fraction, rsp_mon.hit_normal_x,
                    rsp_mon.hit_normal_y};
            if (clip_q.size() == 0) begin
               $error("Response beat arrived with no query outstanding.");
               fail_count++;
            end else begin
               want = clip_q.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, got.hit);
                  fail_count++;
               end
               if (got.fraction !== want.fraction) begin
                  $error("hit_fraction: expected %0d, got %0d", want.fraction, got.fraction);
                  fail_count++;
               end
               if (got.normal_x !== want.normal_x) begin
                  $error("hit_normal_x: expected %0d, got %0d", want.normal_x, got.normal_x);
                  fail_count++;
               end
               if (got.normal_y !== want.normal_y) begin
                  $error("hit_normal_y: expected %0d, got %0d", want.normal_y, got.normal_y);
                  fail_count++;
               end
            end
         end
      end
      pending_count = clip_q.size();
   end

endmodule

### bench/tb_ray_convex_polygon_clip.sv
// Testbench top that drives polygon loads, ray queries and pose settings into the clipper.
module tb_ray_convex_polygon_clip;
   import rcpc_pkg::*;

   localparam real TWO_PI = 6.283185307179586;
   localparam longint CYCLE_LIMIT = 1500000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int fail_count;
   int pending_count;
   longint cycle_count;
   bit sender_gaps;
   real body_xr, body_yr, poly_radius;

   rcpc_req_if req_bus();
   rcpc_rsp_if rsp_bus();

   ray_convex_polygon_clip uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   rcpc_clip_checker clip_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic real unit_rand();
      return real'($urandom_range(0, 100000)) / 100000.0;
   endfunction

   function automatic logic signed [15:0] q14(input real v);
      return 16'(longint'(v * 16384.0));
   endfunction

   function automatic logic [31:0] q16_wrap(input real v);
      return 32'(longint'(v));
   endfunction

   // Receiver: random stalls, plus one long hold-off that backs the block up.
   initial begin
      int taken;
      taken = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (taken == 120) begin
            rsp_bus.ready = 1'b0;
            repeat (3000) @(negedge clock);
            taken++;
         end
         rsp_bus.ready = ($urandom_range(0, 3) != 0) || (idle_length() == 0);
         if (rsp_bus.ready) begin
            @(posedge clock);
            if (rsp_bus.valid) taken++;
         end else begin
            repeat (idle_length()) @(negedge clock);
         end
      end
   end

   task automatic push_beat();
      int gap;
      gap = sender_gaps ? idle_length() : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic load_vertex(input logic [2:0] slot, input logic [31:0] x,
                              input logic [31:0] y, input logic signed [15:0] nx,
                              input logic signed [15:0] ny);
      req_bus.operation = OP_LOAD;
      req_bus.vertex_index = slot;
      req_bus.vert_x = x;
      req_bus.vert_y = y;
      req_bus.edge_nx = nx;
      req_bus.edge_ny = ny;
      push_beat();
   endtask

   task automatic query_ray(input logic [31:0] ox, input logic [31:0] oy,
                            input logic signed [15:0] dx, input logic signed [15:0] dy,
                            input logic [30:0] len);
      req_bus.operation = OP_QUERY;
      req_bus.origin_x = ox;
      req_bus.origin_y = oy;
      req_bus.dir_x = dx;
      req_bus.dir_y = dy;
      req_bus.ray_length = len;
      push_beat();
   endtask

   task automatic load_polygon(input int k, input real r, input real rot);
      real a, na;
      int s;
      for (int i = 0; i < 8; i++) begin
         s = (i < k) ? i : 0;
         a = rot + TWO_PI * s / k;
         na = rot + TWO_PI * (2 * s + 1) / (2 * k);
         load_vertex(3'(i), q16_wrap(r * $cos(a)), q16_wrap(r * $sin(a)),
                     q14($cos(na)), q14($sin(na)));
      end
   endtask

   task automatic aimed_query();
      real a, d, da;
      a = TWO_PI * unit_rand();
      d = poly_radius * (0.5 + 3.0 * unit_rand());
      da = a + TWO_PI / 2.0 + 1.2 * (unit_rand() - 0.5);
      query_ray(q16_wrap(body_xr + d * $cos(a)), q16_wrap(body_yr + d * $sin(a)),
                q14($cos(da)), q14($sin(da)), 31'(longint'(d * (0.2 + 2.0 * unit_rand()))));
   endtask

   task automatic noise_beat();
      if ($urandom_range(0, 3) == 0) begin
         load_vertex(3'($urandom), $urandom, $urandom, 16'($urandom_range(0, 32768) - 16384),
                     16'($urandom_range(0, 32768) - 16384));
      end else begin
         query_ray($urandom, $urandom, 16'($urandom_range(0, 32768) - 16384),
                   16'($urandom_range(0, 32768) - 16384), 31'($urandom));
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic set_pose(input logic [3:0] count, input real x, input real y,
                           input logic signed [15:0] c, input logic signed [15:0] s);
      body_xr = x;
      body_yr = y;
      write_csr(CSR_VERTEX_COUNT, 32'(count));
      write_csr(CSR_POS_X, q16_wrap(x));
      write_csr(CSR_POS_Y, q16_wrap(y));
      write_csr(CSR_ROT_COS, 32'(c));
      write_csr(CSR_ROT_SIN, 32'(s));
   endtask

   initial begin
      logic [3:0] counts [10];
      real ang;
      int k;
      counts = '{4'd3, 4'd8, 4'd15, 4'd0, 4'd5, 4'd1, 4'd6, 4'd8, 4'd7, 4'd2};
      cycle_count = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sender_gaps = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_LOAD;
      req_bus.vertex_index = '0;
      req_bus.vert_x = '0;
      req_bus.vert_y = '0;
      req_bus.edge_nx = '0;
      req_bus.edge_ny = '0;
      req_bus.origin_x = '0;
      req_bus.origin_y = '0;
      req_bus.dir_x = '0;
      req_bus.dir_y = '0;
      req_bus.ray_length = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed part: a square at the origin with the reset pose.
      poly_radius = 65536.0 * 4.0;
      body_xr = 0.0;
      body_yr = 0.0;
      load_polygon(4, poly_radius, -TWO_PI / 8.0);
      query_ray(-32'sd1048576, 32'sd0, 16'sd16384, 16'sd0, 31'd2097152);
      query_ray(32'sd0, 32'sd0, 16'sd16384, 16'sd0, 31'd2097152);
      query_ray(-32'sd1048576, 32'sd0, 16'sd16384, 16'sd0, 31'd0);
      query_ray(-32'sd1048576, 32'sd1048576, 16'sd16384, 16'sd0, 31'd4194304);
      query_ray(32'sd1048576, 32'sd0, -16'sd16384, 16'sd0, 31'h7fffffff);
      query_ray(32'sh7fffffff, 32'sh80000000, -16'sd16384, 16'sd16384, 31'h7fffffff);
      query_ray(32'sh80000000, 32'sh7fffffff, 16'sd16384, -16'sd16384, 31'd1);
      query_ray(32'sd0, -32'sd1048576, 16'sd0, 16'sd16384, 31'd131072);
      load_vertex(3'd3, 32'sh7fffffff, 32'sh80000000, 16'sd16384, -16'sd16384);
      query_ray(32'sd0, -32'sd1048576, 16'sd0, 16'sd16384, 31'd1048576);
      load_vertex(3'd3, 32'sh80000000, 32'sh7fffffff, -16'sd16384, 16'sd16384);
      query_ray(-32'sd1048576, 32'sd0, 16'sd16384, 16'sd0, 31'd2097152);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         sender_gaps = (ph % 3) != 1;
         ang = TWO_PI * unit_rand();
         if (ph == 3) begin
            set_pose(counts[ph], 2147483647.0, -2147483648.0, -16'sd16384, 16'sd16384);
         end else if (ph == 6) begin
            set_pose(counts[ph], -2147483648.0, 2147483647.0, 16'sd16384, -16'sd16384);
         end else begin
            set_pose(counts[ph], 65536.0 * (real'($urandom_range(0, 4000)) - 2000.0),
                     65536.0 * (real'($urandom_range(0, 4000)) - 2000.0),
                     q14($cos(ang)), q14($sin(ang)));
         end
         k = (counts[ph] < 3) ? 3 : ((counts[ph] > 8) ? 8 : counts[ph]);
         poly_radius = 65536.0 * (1.0 + 150.0 * unit_rand());
         load_polygon(k, poly_radius, TWO_PI * unit_rand());
         for (int n = 0; n < 85; n++) begin
            if ($urandom_range(0, 99) < 85) aimed_query();
            else noise_beat();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
rtl/rcpc_pkg.sv
rtl/rcpc_req_if.sv
rtl/rcpc_rsp_if.sv
rtl/rcpc_mac.sv
rtl/rcpc_div.sv
rtl/ray_convex_polygon_clip.sv
bench/rcpc_clip_checker.sv
bench/tb_ray_convex_polygon_clip.sv
